// ===== hdl/nesc_pkg.sv =====
package nesc_pkg;

  // counter store geometry
  localparam int unsigned NumCounters = 383;
  localparam int unsigned IdxWidth    = 9;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned ErrWidth    = 3;
  localparam int unsigned NumSlots    = 3;

  // error codes
  localparam logic [ErrWidth-1:0] ErrNone     = 3'd0;
  localparam logic [ErrWidth-1:0] ErrCat      = 3'd1;
  localparam logic [ErrWidth-1:0] ErrProto    = 3'd2;
  localparam logic [ErrWidth-1:0] ErrDir      = 3'd3;
  localparam logic [ErrWidth-1:0] ErrSize     = 3'd4;
  localparam logic [ErrWidth-1:0] ErrInternal = 3'd5;

  // request actions
  localparam logic [1:0] ActRecord = 2'd0;
  localparam logic [1:0] ActRead   = 2'd1;
  localparam logic [1:0] ActClear  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] RegEnable         = 3'd0;
  localparam logic [2:0] RegTypeRemoteCall = 3'd1;
  localparam logic [2:0] RegTypeDiskless   = 3'd2;
  localparam logic [2:0] RegTypeUpdateSync = 3'd3;
  localparam logic [2:0] RegTypeBroadcast  = 3'd4;
  localparam logic [2:0] RegTypeNameSvc    = 3'd5;
  localparam logic [2:0] RegProtoPrivate   = 3'd6;

  typedef struct packed {
    logic        enable;
    logic [15:0] type_remote_call;
    logic [15:0] type_diskless;
    logic [15:0] type_update_sync;
    logic [15:0] type_broadcast;
    logic [15:0] type_name_service;
    logic [7:0]  proto_private;
  } cfg_t;

  // up to three counter increments and the error code of one record
  typedef struct packed {
    logic [ErrWidth-1:0]                err;
    logic [NumSlots-1:0]                vld;
    logic [NumSlots-1:0][IdxWidth-1:0]  idx;
  } plan_t;

endpackage

// ===== hdl/network_event_statistics_counters.sv =====
// record, if enabled: each counter increment (zero to three) is read, bumped and written
// back; read in range: one counter via the registered ram read port; clear: all counters
// zeroed; others go straight to the result, which turns valid as the sequencer returns to
// idle. one request at a time, set by the single counter ram port pair and the shared
// incrementer (read, add one, write back). a new result waits for the output register to
// drain, then sits there while the next request is taken. reset (async, active low)
// returns config to defaults, then a sweep zeroes all 383 counters before the first accept.
module network_event_statistics_counters #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // requests
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // direction[7:0], arg_a[23:8], arg_b[39:24], arg_c[55:40], read_index[64:56], zero pad
  input  logic [71:0] s_axis_tdata_i,
  // action[1:0], kind[9:2]
  input  logic [9:0]  s_axis_tuser_i,
  // results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // error_code[2:0], read_value[34:3], zero pad
  output logic [39:0] m_axis_tdata_o
);

  localparam int unsigned IdxW = nesc_pkg::IdxWidth;
  localparam int unsigned ErrW = nesc_pkg::ErrWidth;
  localparam int unsigned ValW = nesc_pkg::ValueWidth;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_BUMP_RD,
    S_BUMP_WR,
    S_READ,
    S_RDATA,
    S_CLR,
    S_DONE
  } state_e;

  state_e                 state_q, state_d;
  nesc_pkg::cfg_t         cfg_q, cfg_d;
  nesc_pkg::plan_t        plan_q, plan_d;
  nesc_pkg::plan_t        dec_plan;
  logic [1:0]             slot_q, slot_d;
  logic [IdxW-1:0]        clr_q, clr_d;
  logic [IdxW-1:0]        ridx_q, ridx_d;
  logic [ErrW-1:0]        res_err_q, res_err_d;
  logic [ValW-1:0]        res_val_q, res_val_d;
  logic                   out_vld_q, out_vld_d;
  logic [ErrW-1:0]        out_err_q, out_err_d;
  logic [ValW-1:0]        out_val_q, out_val_d;

  logic [1:0]             action;
  logic [7:0]             kind;
  logic [7:0]             direction;
  logic signed [15:0]     arg_a;
  logic [15:0]            arg_b;
  logic signed [15:0]     arg_c;
  logic [IdxW-1:0]        read_index;

  logic                   ram_we;
  logic [IdxW-1:0]        ram_waddr;
  logic [COUNTER_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [IdxW-1:0]        ram_raddr;
  logic [COUNTER_WIDTH-1:0] ram_rdata;
  logic [ValW-1:0]        rd_low;

  // request field unpacking
  assign action     = s_axis_tuser_i[1:0];
  assign kind       = s_axis_tuser_i[9:2];
  assign direction  = s_axis_tdata_i[7:0];
  assign arg_a      = s_axis_tdata_i[23:8];
  assign arg_b      = s_axis_tdata_i[39:24];
  assign arg_c      = s_axis_tdata_i[55:40];
  assign read_index = s_axis_tdata_i[64:56];

  nesc_decode u_decode (
    .kind_i      (kind),
    .direction_i (direction),
    .arg_a_i     (arg_a),
    .arg_b_i     (arg_b),
    .arg_c_i     (arg_c),
    .cfg_i       (cfg_q),
    .plan_o      (dec_plan)
  );

  nesc_ram #(
    .Width (COUNTER_WIDTH),
    .Depth (nesc_pkg::NumCounters)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // low 32 bits of a counter
  if (COUNTER_WIDTH >= ValW) begin : g_wide
    assign rd_low = ram_rdata[ValW-1:0];
  end else begin : g_narrow
    assign rd_low = {{(ValW - COUNTER_WIDTH){1'b0}}, ram_rdata};
  end

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'd0, out_val_q, out_err_q};

  // config register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        nesc_pkg::RegEnable:         cfg_d.enable            = cfg_data_i[0];
        nesc_pkg::RegTypeRemoteCall: cfg_d.type_remote_call  = cfg_data_i;
        nesc_pkg::RegTypeDiskless:   cfg_d.type_diskless     = cfg_data_i;
        nesc_pkg::RegTypeUpdateSync: cfg_d.type_update_sync  = cfg_data_i;
        nesc_pkg::RegTypeBroadcast:  cfg_d.type_broadcast    = cfg_data_i;
        nesc_pkg::RegTypeNameSvc:    cfg_d.type_name_service = cfg_data_i;
        nesc_pkg::RegProtoPrivate:   cfg_d.proto_private     = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // counter ram port control, shared incrementer on the write data
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = plan_q.idx[slot_q];
    ram_wdata = ram_rdata + COUNTER_WIDTH'(1);
    ram_re    = 1'b0;
    ram_raddr = plan_q.idx[slot_q];
    case (state_q)
      S_INIT, S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      S_BUMP_RD: begin
        ram_re = plan_q.vld[slot_q];
      end
      S_BUMP_WR: begin
        ram_we = 1'b1;
      end
      S_READ: begin
        ram_re    = 1'b1;
        ram_raddr = ridx_q;
      end
      default: ;
    endcase
  end

  // request sequencer
  always_comb begin
    state_d   = state_q;
    plan_d    = plan_q;
    slot_d    = slot_q;
    clr_d     = clr_q;
    ridx_d    = ridx_q;
    res_err_d = res_err_q;
    res_val_d = res_val_q;
    out_vld_d = out_vld_q && !m_axis_tready_i;
    out_err_d = out_err_q;
    out_val_d = out_val_q;
    case (state_q)
      S_INIT: begin
        clr_d = clr_q + IdxW'(1);
        if (clr_q == IdxW'(nesc_pkg::NumCounters - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          plan_d    = dec_plan;
          ridx_d    = read_index;
          slot_d    = '0;
          clr_d     = '0;
          res_err_d = nesc_pkg::ErrNone;
          res_val_d = '0;
          case (action)
            nesc_pkg::ActRecord: begin
              if (cfg_q.enable) begin
                res_err_d = dec_plan.err;
                state_d   = S_BUMP_RD;
              end else begin
                state_d = S_DONE;
              end
            end
            nesc_pkg::ActRead: begin
              if (read_index < IdxW'(nesc_pkg::NumCounters)) begin
                state_d = S_READ;
              end else begin
                state_d = S_DONE;
              end
            end
            nesc_pkg::ActClear: begin
              state_d = S_CLR;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_BUMP_RD: begin
        if (plan_q.vld[slot_q]) begin
          state_d = S_BUMP_WR;
        end else if (slot_q == 2'd2) begin
          state_d = S_DONE;
        end else begin
          slot_d = slot_q + 2'd1;
        end
      end
      S_BUMP_WR: begin
        if (slot_q == 2'd2) begin
          state_d = S_DONE;
        end else begin
          slot_d  = slot_q + 2'd1;
          state_d = S_BUMP_RD;
        end
      end
      S_READ: begin
        state_d = S_RDATA;
      end
      S_RDATA: begin
        res_val_d = rd_low;
        state_d   = S_DONE;
      end
      S_CLR: begin
        clr_d = clr_q + IdxW'(1);
        if (clr_q == IdxW'(nesc_pkg::NumCounters - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hand the result over once the output register is free
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d = 1'b1;
          out_err_d = res_err_q;
          out_val_d = res_val_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q                 <= S_INIT;
      slot_q                  <= '0;
      clr_q                   <= '0;
      out_vld_q               <= 1'b0;
      cfg_q.enable            <= 1'b0;
      cfg_q.type_remote_call  <= 16'd1;
      cfg_q.type_diskless     <= 16'd2;
      cfg_q.type_update_sync  <= 16'd3;
      cfg_q.type_broadcast    <= 16'd4;
      cfg_q.type_name_service <= 16'd5;
      cfg_q.proto_private     <= 8'd254;
    end else begin
      state_q   <= state_d;
      slot_q    <= slot_d;
      clr_q     <= clr_d;
      out_vld_q <= out_vld_d;
      cfg_q     <= cfg_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    plan_q    <= plan_d;
    ridx_q    <= ridx_d;
    res_err_q <= res_err_d;
    res_val_q <= res_val_d;
    out_err_q <= out_err_d;
    out_val_q <= out_val_d;
  end

endmodule

// ===== hdl/nesc_ram.sv =====
module nesc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 383
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/nesc_decode.sv =====
module nesc_decode (
  input  logic [7:0]          kind_i,
  input  logic [7:0]          direction_i,
  input  logic signed [15:0]  arg_a_i,
  input  logic [15:0]         arg_b_i,
  input  logic signed [15:0]  arg_c_i,
  input  nesc_pkg::cfg_t      cfg_i,
  output nesc_pkg::plan_t     plan_o
);

  localparam logic [7:0] KindOffset = 8'd7;
  localparam logic [7:0] KindCall   = 8'd8;
  localparam logic [7:0] KindEth    = 8'd9;
  localparam logic [7:0] KindBuffer = 8'd10;
  localparam logic [7:0] KindConn   = 8'd11;
  localparam logic [7:0] KindPort   = 8'd12;

  localparam logic [7:0] DirTx = 8'd1;
  localparam logic [7:0] DirRx = 8'd2;

  localparam logic [8:0] BaseEthRx = 9'd0;
  localparam logic [8:0] BaseEthTx = 9'd19;
  localparam logic [8:0] BaseRpcRx = 9'd38;
  localparam logic [8:0] BaseRpcTx = 9'd50;
  localparam logic [8:0] BaseOfsRx = 9'd62;
  localparam logic [8:0] BaseOfsTx = 9'd220;
  localparam logic [8:0] BaseBuf   = 9'd378;
  localparam logic [8:0] BaseCon   = 9'd380;
  localparam logic [8:0] BasePort  = 9'd382;

  localparam logic [15:0] CatMain     = 16'h000f;
  localparam logic [15:0] CatMinusOne = 16'hffff;
  localparam logic [15:0] EtherIpv4   = 16'h0800;
  localparam logic [15:0] EtherArp    = 16'h0806;
  localparam logic [7:0]  ProtoIcmp   = 8'd1;

  logic               dir_ok;
  logic               is_tx;
  logic [15:0]        a_u;
  logic [15:0]        c_u;
  logic signed [17:0] a_ext;
  logic signed [17:0] bin;
  logic               has_bin;
  logic [8:0]         first;
  logic [8:0]         base;
  logic               main_cat;
  logic [8:0]         second;

  assign dir_ok = (direction_i == DirTx) || (direction_i == DirRx);
  assign is_tx  = (direction_i == DirTx);
  assign a_u    = arg_a_i;
  assign c_u    = arg_c_i;
  assign a_ext  = 18'(arg_a_i);

  // record decode into counter indexes
  always_comb begin
    plan_o   = '0;
    bin      = '0;
    has_bin  = 1'b0;
    first    = '0;
    base     = '0;
    main_cat = 1'b0;
    second   = '0;
    case (kind_i)
      KindOffset: begin
        base = is_tx ? BaseOfsTx : BaseOfsRx;
        if (!dir_ok) begin
          plan_o.err = nesc_pkg::ErrDir;
        end else if (arg_b_i != CatMain) begin
          plan_o.err = nesc_pkg::ErrCat;
        end else begin
          has_bin = 1'b1;
          if (c_u == cfg_i.type_remote_call) begin
            if (arg_a_i < 16'sd0) begin
              bin   = 18'sd98 - a_ext;
              first = base + 9'd2;
            end else begin
              bin   = a_ext;
              first = base + 9'd1;
            end
          end else if (c_u == cfg_i.type_diskless) begin
            bin   = a_ext + 18'sd132;
            first = base + 9'd3;
          end else if (c_u == cfg_i.type_update_sync) begin
            has_bin = 1'b0;
          end else if (c_u == cfg_i.type_broadcast) begin
            if (arg_a_i != 16'sd1) begin
              has_bin    = 1'b0;
              plan_o.err = nesc_pkg::ErrProto;
            end else begin
              bin   = 18'sd1;
              first = base + 9'd1;
            end
          end else begin
            if (arg_a_i != -16'sd20) begin
              has_bin    = 1'b0;
              plan_o.err = nesc_pkg::ErrProto;
            end else begin
              bin   = 18'sd118;
              first = base + 9'd2;
            end
          end
          if (has_bin) begin
            plan_o.vld[0] = 1'b1;
            plan_o.idx[0] = first;
            // only bins 0 to 153 exist
            if (bin < 18'sd0 || bin > 18'sd153) begin
              plan_o.err = nesc_pkg::ErrInternal;
            end else begin
              plan_o.vld[1] = 1'b1;
              plan_o.idx[1] = base;
              plan_o.vld[2] = 1'b1;
              plan_o.idx[2] = base + 9'd4 + bin[8:0];
            end
          end
        end
      end
      KindCall: begin
        base = is_tx ? BaseRpcTx : BaseRpcRx;
        if (!dir_ok) begin
          plan_o.err = nesc_pkg::ErrDir;
        end else begin
          plan_o.vld[0] = 1'b1;
          if (arg_b_i == CatMain) begin
            main_cat = 1'b1;
            plan_o.idx[0] = base;
          end else if (is_tx && arg_b_i == 16'h0013) begin
            plan_o.idx[0] = base + 9'd1;
          end else if (is_tx && arg_b_i == 16'h0014) begin
            plan_o.idx[0] = base + 9'd2;
          end else if (!is_tx && arg_b_i == 16'h0015) begin
            plan_o.idx[0] = base + 9'd1;
          end else if (!is_tx && arg_b_i == 16'h0016) begin
            plan_o.idx[0] = base + 9'd2;
          end else if (!is_tx && arg_b_i == 16'h0017) begin
            plan_o.idx[0] = base + 9'd3;
          end else if (!is_tx && arg_b_i == 16'h0019) begin
            plan_o.idx[0] = base + 9'd4;
          end else if (!is_tx && arg_b_i == 16'h0014) begin
            plan_o.idx[0] = base + 9'd5;
          end else begin
            plan_o.vld[0] = 1'b0;
            plan_o.err    = nesc_pkg::ErrCat;
          end
          // packet type bin on the main category
          if (main_cat) begin
            if (a_u == cfg_i.type_remote_call) begin
              second = base + 9'd6;
            end else if (a_u == cfg_i.type_broadcast) begin
              second = base + 9'd7;
            end else if (a_u == cfg_i.type_diskless) begin
              second = base + 9'd8;
            end else if (a_u == cfg_i.type_update_sync) begin
              second = base + 9'd9;
            end else if (a_u == cfg_i.type_name_service) begin
              second = base + 9'd10;
            end else begin
              second = base + 9'd11;
            end
            plan_o.vld[1] = 1'b1;
            plan_o.idx[1] = second;
          end
        end
      end
      KindEth: begin
        base = is_tx ? BaseEthTx : BaseEthRx;
        if (!dir_ok) begin
          plan_o.err = nesc_pkg::ErrDir;
        end else if (arg_b_i == CatMain) begin
          plan_o.vld[0] = 1'b1;
          plan_o.idx[0] = base;
          plan_o.vld[1] = 1'b1;
          if (a_u == EtherIpv4) begin
            plan_o.idx[1] = base + 9'd5;
          end else if (a_u == EtherArp) begin
            plan_o.idx[1] = base + 9'd6;
          end else begin
            plan_o.idx[1] = base + 9'd7;
          end
          // frame size bins over 60 to 1514 bytes
          if (arg_c_i < 16'sd60 || arg_c_i > 16'sd1514) begin
            plan_o.err = nesc_pkg::ErrSize;
          end else begin
            plan_o.vld[2] = 1'b1;
            if (arg_c_i > 16'sd1024) begin
              plan_o.idx[2] = base + 9'd11;
            end else if (arg_c_i > 16'sd512) begin
              plan_o.idx[2] = base + 9'd12;
            end else if (arg_c_i > 16'sd256) begin
              plan_o.idx[2] = base + 9'd13;
            end else if (arg_c_i > 16'sd128) begin
              plan_o.idx[2] = base + 9'd14;
            end else begin
              plan_o.idx[2] = base + 9'd15;
            end
          end
        end else if (arg_b_i == CatMinusOne) begin
          // ip protocol bins
          plan_o.vld[0] = 1'b1;
          if (a_u[7:0] == cfg_i.proto_private) begin
            plan_o.idx[0] = base + 9'd8;
          end else if (a_u[7:0] == ProtoIcmp) begin
            plan_o.idx[0] = base + 9'd9;
          end else begin
            plan_o.idx[0] = base + 9'd10;
          end
        end else begin
          plan_o.vld[0] = 1'b1;
          if (is_tx && arg_b_i == 16'h0013) begin
            plan_o.idx[0] = base + 9'd1;
          end else if (is_tx && arg_b_i == 16'h0014) begin
            plan_o.idx[0] = base + 9'd2;
          end else if (!is_tx && arg_b_i == 16'h0010) begin
            plan_o.idx[0] = base + 9'd2;
          end else if (!is_tx && arg_b_i == 16'h0011) begin
            plan_o.idx[0] = base + 9'd3;
          end else if (!is_tx && arg_b_i == 16'h0018) begin
            plan_o.idx[0] = base + 9'd4;
          end else if (!is_tx && arg_b_i == 16'h0019) begin
            plan_o.idx[0] = base + 9'd1;
          end else begin
            plan_o.vld[0] = 1'b0;
            plan_o.err    = nesc_pkg::ErrCat;
          end
        end
      end
      KindBuffer: begin
        if (direction_i == 8'h1a || direction_i == 8'h1b) begin
          plan_o.vld[0] = 1'b1;
          plan_o.idx[0] = BaseBuf + {8'd0, direction_i[0]};
        end else begin
          plan_o.err = nesc_pkg::ErrDir;
        end
      end
      KindConn: begin
        if (direction_i == 8'h1c || direction_i == 8'h1d) begin
          plan_o.vld[0] = 1'b1;
          plan_o.idx[0] = BaseCon + {8'd0, direction_i[0]};
        end else begin
          plan_o.err = nesc_pkg::ErrDir;
        end
      end
      KindPort: begin
        if (direction_i == 8'h1e) begin
          plan_o.vld[0] = 1'b1;
          plan_o.idx[0] = BasePort;
        end else begin
          plan_o.err = nesc_pkg::ErrDir;
        end
      end
      default: begin
        plan_o.err = nesc_pkg::ErrInternal;
      end
    endcase
  end

endmodule

// ===== tb/network_event_statistics_counters_tb.sv =====
module network_event_statistics_counters_tb;

  // record kinds
  localparam logic [7:0] KindOffset = 8'd7;
  localparam logic [7:0] KindCall   = 8'd8;
  localparam logic [7:0] KindEth    = 8'd9;
  localparam logic [7:0] KindBuffer = 8'd10;
  localparam logic [7:0] KindConn   = 8'd11;
  localparam logic [7:0] KindPort   = 8'd12;

  // action with no effect
  localparam logic [1:0] ActIdle = 2'd3;

  // counter sets
  localparam logic [7:0] DirSend = 8'd1;
  localparam logic [7:0] DirRecv = 8'd2;

  // category codes
  localparam logic [15:0] CatMain     = 16'h000f;
  localparam logic [15:0] CatX10      = 16'h0010;
  localparam logic [15:0] CatX11      = 16'h0011;
  localparam logic [15:0] CatX13      = 16'h0013;
  localparam logic [15:0] CatX14      = 16'h0014;
  localparam logic [15:0] CatX15      = 16'h0015;
  localparam logic [15:0] CatX16      = 16'h0016;
  localparam logic [15:0] CatX17      = 16'h0017;
  localparam logic [15:0] CatX18      = 16'h0018;
  localparam logic [15:0] CatX19      = 16'h0019;
  localparam logic [15:0] CatMinusOne = 16'hffff;

  // protocol numbers
  localparam logic [15:0] EtherIpv4   = 16'h0800;
  localparam logic [15:0] EtherArp    = 16'h0806;
  localparam logic [7:0]  IpProtoIcmp = 8'd1;

  // codes of the simple bins
  localparam logic [7:0] BufFirst  = 8'h1a;
  localparam logic [7:0] ConnFirst = 8'h1c;
  localparam logic [7:0] PortFirst = 8'h1e;

  // flat counter layout
  localparam int unsigned BaseEthRx  = 0;
  localparam int unsigned BaseEthTx  = 19;
  localparam int unsigned BaseCallRx = 38;
  localparam int unsigned BaseCallTx = 50;
  localparam int unsigned BaseOfsRx  = 62;
  localparam int unsigned BaseOfsTx  = 220;
  localparam int unsigned BaseBuf    = 378;
  localparam int unsigned BaseConn   = 380;
  localparam int unsigned BasePort   = 382;
  localparam int          OfsBinLast = 153;

  localparam int unsigned ErrW = nesc_pkg::ErrWidth;
  localparam int unsigned ValW = nesc_pkg::ValueWidth;
  localparam int unsigned NumCtr = nesc_pkg::NumCounters;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  kind;
    logic [7:0]  dir;
    logic [15:0] arg_a;
    logic [15:0] arg_b;
    logic [15:0] arg_c;
    logic [8:0]  read_index;
  } stats_req_t;

  typedef struct packed {
    logic [ErrW-1:0] err;
    logic [ValW-1:0] value;
  } stats_reply_t;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i     = '0;
  logic [15:0] cfg_data_i      = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [71:0] s_axis_tdata_i  = '0;
  logic [9:0]  s_axis_tuser_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;

  // shadow of the counter store and the registers
  logic [ValW-1:0]       shadow_ctr [NumCtr];
  nesc_pkg::cfg_t        model_cfg;

  stats_req_t   request_q [$];
  stats_reply_t reply_q [$];
  int unsigned  outstanding  = 0;
  int unsigned  fail_cnt     = 0;
  int unsigned  src_idle_pct = 0;
  int unsigned  snk_idle_pct = 0;
  logic         req_taken    = 1'b0;

  network_event_statistics_counters u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #500000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  function automatic void bump_ctr(int unsigned idx);
    if (idx < NumCtr) shadow_ctr[idx] = shadow_ctr[idx] + 1'b1;
  endfunction

  function automatic logic [ErrW-1:0] tally_offset(logic [7:0] dir, int cnt,
                                                   logic [15:0] cat, logic [15:0] ptype);
    int unsigned base;
    int          bin;
    if (dir != DirSend && dir != DirRecv) return nesc_pkg::ErrDir;
    base = (dir == DirSend) ? BaseOfsTx : BaseOfsRx;
    if (cat != CatMain) return nesc_pkg::ErrCat;
    // first matching register wins
    if (ptype == model_cfg.type_remote_call) begin
      if (cnt < 0) begin
        bin = 98 - cnt;
        bump_ctr(base + 2);
      end else begin
        bin = cnt;
        bump_ctr(base + 1);
      end
    end else if (ptype == model_cfg.type_diskless) begin
      bin = cnt + 132;
      bump_ctr(base + 3);
    end else if (ptype == model_cfg.type_update_sync) begin
      return nesc_pkg::ErrNone;
    end else if (ptype == model_cfg.type_broadcast) begin
      if (cnt != 1) return nesc_pkg::ErrProto;
      bin = 1;
      bump_ctr(base + 1);
    end else begin
      if (cnt != -20) return nesc_pkg::ErrProto;
      bin = 118;
      bump_ctr(base + 2);
    end
    // sign bin already counted when the offset bin is missing
    if (bin < 0 || bin > OfsBinLast) return nesc_pkg::ErrInternal;
    bump_ctr(base);
    bump_ctr(base + 4 + bin);
    return nesc_pkg::ErrNone;
  endfunction

  function automatic logic [ErrW-1:0] tally_call(logic [7:0] dir, logic [15:0] ptype,
                                                 logic [15:0] cat);
    int unsigned base;
    if (dir == DirSend) begin
      base = BaseCallTx;
      case (cat)
        CatMain: bump_ctr(base);
        CatX13: begin bump_ctr(base + 1); return nesc_pkg::ErrNone; end
        CatX14: begin bump_ctr(base + 2); return nesc_pkg::ErrNone; end
        default: return nesc_pkg::ErrCat;
      endcase
    end else if (dir == DirRecv) begin
      base = BaseCallRx;
      case (cat)
        CatMain: bump_ctr(base);
        CatX15: begin bump_ctr(base + 1); return nesc_pkg::ErrNone; end
        CatX16: begin bump_ctr(base + 2); return nesc_pkg::ErrNone; end
        CatX17: begin bump_ctr(base + 3); return nesc_pkg::ErrNone; end
        CatX19: begin bump_ctr(base + 4); return nesc_pkg::ErrNone; end
        CatX14: begin bump_ctr(base + 5); return nesc_pkg::ErrNone; end
        default: return nesc_pkg::ErrCat;
      endcase
    end else begin
      return nesc_pkg::ErrDir;
    end
    if (ptype == model_cfg.type_remote_call) bump_ctr(base + 6);
    else if (ptype == model_cfg.type_broadcast) bump_ctr(base + 7);
    else if (ptype == model_cfg.type_diskless) bump_ctr(base + 8);
    else if (ptype == model_cfg.type_update_sync) bump_ctr(base + 9);
    else if (ptype == model_cfg.type_name_service) bump_ctr(base + 10);
    else bump_ctr(base + 11);
    return nesc_pkg::ErrNone;
  endfunction

  function automatic logic [ErrW-1:0] tally_eth(logic [7:0] dir, logic [15:0] proto,
                                                logic [15:0] cat, int size);
    int unsigned base;
    if (dir == DirSend) begin
      base = BaseEthTx;
      case (cat)
        CatMain: bump_ctr(base);
        CatX13: begin bump_ctr(base + 1); return nesc_pkg::ErrNone; end
        CatX14: begin bump_ctr(base + 2); return nesc_pkg::ErrNone; end
        CatMinusOne: ;
        default: return nesc_pkg::ErrCat;
      endcase
    end else if (dir == DirRecv) begin
      base = BaseEthRx;
      case (cat)
        CatMain: bump_ctr(base);
        CatX10: begin bump_ctr(base + 2); return nesc_pkg::ErrNone; end
        CatX11: begin bump_ctr(base + 3); return nesc_pkg::ErrNone; end
        CatX18: begin bump_ctr(base + 4); return nesc_pkg::ErrNone; end
        CatX19: begin bump_ctr(base + 1); return nesc_pkg::ErrNone; end
        CatMinusOne: ;
        default: return nesc_pkg::ErrCat;
      endcase
    end else begin
      return nesc_pkg::ErrDir;
    end
    // minus-one category: ip protocol bins only
    if (cat != CatMain) begin
      if (proto[7:0] == model_cfg.proto_private) bump_ctr(base + 8);
      else if (proto[7:0] == IpProtoIcmp) bump_ctr(base + 9);
      else bump_ctr(base + 10);
      return nesc_pkg::ErrNone;
    end
    if (proto == EtherIpv4) bump_ctr(base + 5);
    else if (proto == EtherArp) bump_ctr(base + 6);
    else bump_ctr(base + 7);
    // frame size bins, protocol bin already counted on a bad size
    if (size < 60 || size > 1514) return nesc_pkg::ErrSize;
    if (size > 1024) bump_ctr(base + 11);
    else if (size > 512) bump_ctr(base + 12);
    else if (size > 256) bump_ctr(base + 13);
    else if (size > 128) bump_ctr(base + 14);
    else bump_ctr(base + 15);
    return nesc_pkg::ErrNone;
  endfunction

  function automatic logic [ErrW-1:0] tally_simple(logic [7:0] code, logic [7:0] first,
                                                   int unsigned base, int unsigned span);
    if (code >= first && code < first + span) begin
      bump_ctr(base + (code - first));
      return nesc_pkg::ErrNone;
    end
    return nesc_pkg::ErrDir;
  endfunction

  function automatic stats_reply_t predict_reply(stats_req_t r);
    stats_reply_t res;
    res = '0;
    case (r.action)
      nesc_pkg::ActRecord: begin
        if (model_cfg.enable) begin
          case (r.kind)
            KindOffset: res.err = tally_offset(r.dir, int'($signed(r.arg_a)), r.arg_b, r.arg_c);
            KindCall:   res.err = tally_call(r.dir, r.arg_a, r.arg_b);
            KindEth:    res.err = tally_eth(r.dir, r.arg_a, r.arg_b, int'($signed(r.arg_c)));
            KindBuffer: res.err = tally_simple(r.dir, BufFirst, BaseBuf, 2);
            KindConn:   res.err = tally_simple(r.dir, ConnFirst, BaseConn, 2);
            KindPort:   res.err = tally_simple(r.dir, PortFirst, BasePort, 1);
            default:    res.err = nesc_pkg::ErrInternal;
          endcase
        end
      end
      nesc_pkg::ActRead: begin
        if (r.read_index < NumCtr) res.value = shadow_ctr[r.read_index];
      end
      nesc_pkg::ActClear: begin
        foreach (shadow_ctr[i]) shadow_ctr[i] = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic stats_req_t mk_req(logic [1:0] action, logic [7:0] kind, logic [7:0] dir,
                                        logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                        logic [8:0] idx);
    stats_req_t r;
    r.action     = action;
    r.kind       = kind;
    r.dir        = dir;
    r.arg_a      = a;
    r.arg_b      = b;
    r.arg_c      = c;
    r.read_index = idx;
    return r;
  endfunction

  // one of the configured type codes most of the time
  function automatic logic [15:0] pick_type();
    case ($urandom_range(5))
      0: return model_cfg.type_remote_call;
      1: return model_cfg.type_diskless;
      2: return model_cfg.type_update_sync;
      3: return model_cfg.type_broadcast;
      4: return model_cfg.type_name_service;
      default: return 16'($urandom);
    endcase
  endfunction

  // valid categories for the kind and direction, main category favoured
  function automatic logic [15:0] pick_category(logic [7:0] kind, logic [7:0] dir);
    int unsigned sel;
    sel = $urandom_range(11);
    if (sel < 5) return CatMain;
    if (sel == 11) return 16'($urandom);
    if (kind == KindCall) begin
      if (dir == DirSend) return (sel < 8) ? CatX13 : CatX14;
      case (sel)
        5: return CatX15;
        6: return CatX16;
        7: return CatX17;
        8: return CatX19;
        default: return CatX14;
      endcase
    end
    if (dir == DirSend) begin
      if (sel < 7) return CatX13;
      return (sel < 9) ? CatX14 : CatMinusOne;
    end
    case (sel)
      5: return CatX10;
      6: return CatX11;
      7: return CatX18;
      8: return CatX19;
      default: return CatMinusOne;
    endcase
  endfunction

  function automatic logic [15:0] pick_frame_size();
    case ($urandom_range(7))
      5: begin
        case ($urandom_range(11))
          0: return 16'd59;
          1: return 16'd60;
          2: return 16'd128;
          3: return 16'd129;
          4: return 16'd256;
          5: return 16'd257;
          6: return 16'd512;
          7: return 16'd513;
          8: return 16'd1024;
          9: return 16'd1025;
          10: return 16'd1514;
          default: return 16'd1515;
        endcase
      end
      6: return 16'($urandom);
      7: return 16'($urandom_range(200, 60));
      default: return 16'($urandom_range(1514, 60));
    endcase
  endfunction

  function automatic stats_req_t make_random_request();
    stats_req_t  r;
    int unsigned pick;
    int          cnt;
    r.action     = 2'($urandom);
    r.kind       = 8'($urandom);
    r.dir        = 8'($urandom);
    r.arg_a      = 16'($urandom);
    r.arg_b      = 16'($urandom);
    r.arg_c      = 16'($urandom);
    r.read_index = 9'($urandom);
    pick = $urandom_range(99);
    // raw noise
    if (pick < 8) return r;
    if (pick < 38) begin
      r.action = nesc_pkg::ActRead;
      if ($urandom_range(9) == 0) r.read_index = 9'($urandom_range(511, NumCtr));
      else r.read_index = 9'($urandom_range(NumCtr - 1));
      return r;
    end
    if (pick < 40) begin
      r.action = ActIdle;
      return r;
    end
    if (pick < 41) begin
      r.action = nesc_pkg::ActClear;
      return r;
    end
    // well-formed record with random content
    r.action = nesc_pkg::ActRecord;
    if ($urandom_range(19) != 0) r.kind = 8'($urandom_range(KindPort, KindOffset));
    if ($urandom_range(14) != 0) r.dir = $urandom_range(1) ? DirSend : DirRecv;
    case (r.kind)
      KindOffset: begin
        r.arg_b = ($urandom_range(11) == 0) ? 16'($urandom) : CatMain;
        r.arg_c = pick_type();
        case ($urandom_range(5))
          0: cnt = $urandom_range(OfsBinLast);
          1: cnt = -int'($urandom_range(55, 1));
          2: cnt = int'($urandom_range(OfsBinLast)) - 132;
          3: cnt = 1;
          4: cnt = -20;
          default: cnt = int'($urandom_range(65535)) - 32768;
        endcase
        r.arg_a = 16'(cnt);
      end
      KindCall: begin
        r.arg_a = pick_type();
        r.arg_b = pick_category(r.kind, r.dir);
      end
      KindEth: begin
        case ($urandom_range(4))
          0: r.arg_a = EtherIpv4;
          1: r.arg_a = EtherArp;
          2: r.arg_a = {8'($urandom), model_cfg.proto_private};
          3: r.arg_a = {8'($urandom), IpProtoIcmp};
          default: ;
        endcase
        r.arg_b = pick_category(r.kind, r.dir);
        r.arg_c = pick_frame_size();
      end
      KindBuffer: if ($urandom_range(3) != 0) r.dir = BufFirst + 8'($urandom_range(1));
      KindConn:   if ($urandom_range(3) != 0) r.dir = ConnFirst + 8'($urandom_range(1));
      KindPort:   if ($urandom_range(3) != 0) r.dir = PortFirst;
      default: ;
    endcase
    return r;
  endfunction

  task automatic send(stats_req_t r);
    request_q.push_back(r);
    outstanding++;
  endtask

  task automatic send_random(int unsigned n);
    repeat (n) send(make_random_request());
  endtask

  // every request answered before the registers move
  task automatic wait_idle();
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      nesc_pkg::RegEnable:         model_cfg.enable            = data[0];
      nesc_pkg::RegTypeRemoteCall: model_cfg.type_remote_call  = data;
      nesc_pkg::RegTypeDiskless:   model_cfg.type_diskless     = data;
      nesc_pkg::RegTypeUpdateSync: model_cfg.type_update_sync  = data;
      nesc_pkg::RegTypeBroadcast:  model_cfg.type_broadcast    = data;
      nesc_pkg::RegTypeNameSvc:    model_cfg.type_name_service = data;
      nesc_pkg::RegProtoPrivate:   model_cfg.proto_private     = data[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------- request driver

  always @(negedge clk_i) begin : drive_requests
    stats_req_t nxt;
    if (!s_axis_tvalid_i || req_taken) begin
      if (request_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = request_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= {7'b0, nxt.read_index, nxt.arg_c, nxt.arg_b, nxt.arg_a, nxt.dir};
        s_axis_tuser_i  <= {nxt.kind, nxt.action};
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) m_axis_tready_i <= ($urandom_range(99) >= snk_idle_pct);

  // ---------------------------------------------------------------- reply checker

  always @(posedge clk_i) begin : check_replies
    stats_reply_t exp_r;
    stats_req_t   rq;
    req_taken = s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (reply_q.size() == 0) begin
          $error("reply with no request pending: error_code %0d read_value %0d",
                 m_axis_tdata_o[2:0], m_axis_tdata_o[34:3]);
          fail_cnt++;
        end else begin
          exp_r = reply_q.pop_front();
          outstanding--;
          if (m_axis_tdata_o[2:0] !== exp_r.err) begin
            $error("error_code: expected %0d, got %0d", exp_r.err, m_axis_tdata_o[2:0]);
            fail_cnt++;
          end
          if (m_axis_tdata_o[34:3] !== exp_r.value) begin
            $error("read_value: expected %0d, got %0d", exp_r.value, m_axis_tdata_o[34:3]);
            fail_cnt++;
          end
        end
      end
      // predict after the check so a reply never meets its own request
      if (req_taken) begin
        rq.dir        = s_axis_tdata_i[7:0];
        rq.arg_a      = s_axis_tdata_i[23:8];
        rq.arg_b      = s_axis_tdata_i[39:24];
        rq.arg_c      = s_axis_tdata_i[55:40];
        rq.read_index = s_axis_tdata_i[64:56];
        rq.action     = s_axis_tuser_i[1:0];
        rq.kind       = s_axis_tuser_i[9:2];
        reply_q.push_back(predict_reply(rq));
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : run_test
    foreach (shadow_ctr[i]) shadow_ctr[i] = '0;
    model_cfg = '{enable: 1'b0, type_remote_call: 16'd1, type_diskless: 16'd2,
                  type_update_sync: 16'd3, type_broadcast: 16'd4,
                  type_name_service: 16'd5, proto_private: 8'd254};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    src_idle_pct = 9;
    snk_idle_pct = 69;

    // disabled: records ignored, read and idle still answer
    send(mk_req(nesc_pkg::ActRecord, KindOffset, DirSend, 16'd5, CatMain, 16'd1, 9'd0));
    send(mk_req(nesc_pkg::ActRecord, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 9'd0));
    send(mk_req(nesc_pkg::ActRead, KindOffset, DirSend, 16'd0, 16'd0, 16'd0, 9'd62));
    send(mk_req(ActIdle, 8'hff, 8'hff, 16'hffff, 16'hffff, 16'hffff, 9'h1ff));
    wait_idle();
    write_reg(nesc_pkg::RegEnable, 16'h0001);

    // offset kinds: every type path, bad count, range miss, bad direction with a bad category
    send(mk_req(nesc_pkg::ActRecord, KindOffset, DirSend, 16'd5, CatMain,
                model_cfg.type_remote_call, 9'd0));
    send(mk_req(nesc_pkg::ActRecord, KindOffset, DirRecv, -16'sd3, CatMain,
                model_cfg.type_remote_call, 9'd0));
    send(mk_req(nesc_pkg::ActRecord, KindOffset, DirSend, -16'sd132, CatMain,
                model_cfg.type_diskless, 9'd0));
    send(mk_req(nesc_pkg::ActRecord, KindOffset, DirRecv, 16'd7, CatMain,
                model_cfg.type_update_sync, 9'd0));
    send(mk_req(nesc_pkg::ActRecord, KindOffset, DirSend, 16'd1, CatMain,
                model_cfg.type_broadcast, 9'd0));
    send(mk_req(nesc_pkg::ActRecord, KindOffset, DirSend, 16'd2, CatMain,
                model_cfg.type_broadcast, 9'd0));
    send(mk_req(nesc_pkg::ActRecord, KindOffset, DirRecv, -16'sd20, CatMain, 16'h8000,
                9'd0));
    send(mk_req(nesc_pkg::ActRecord, KindOffset, DirSend, 16'h7fff, CatMain,
                model_cfg.type_remote_call, 9'd0));
    send(mk_req(nesc_pkg::ActRecord, KindOffset, 8'd3, 16'h8000, CatX10, 16'h7fff, 9'd0));
    // remote call records
    send(mk_req(nesc_pkg::ActRecord, KindCall, DirSend, model_cfg.type_name_service,
                CatMain, 16'd0, 9'd0));
    send(mk_req(nesc_pkg::ActRecord, KindCall, DirRecv, 16'd0, CatX19, 16'd0, 9'd0));
    send(mk_req(nesc_pkg::ActRecord, KindCall, DirSend, 16'd0, CatX15, 16'd0, 9'd0));
    // ethernet records, size limits and the minus-one category
    send(mk_req(nesc_pkg::ActRecord, KindEth, DirSend, EtherIpv4, CatMain, 16'd60, 9'd0));
    send(mk_req(nesc_pkg::ActRecord, KindEth, DirRecv, EtherArp, CatMain, 16'd1514, 9'd0));
    send(mk_req(nesc_pkg::ActRecord, KindEth, DirSend, 16'h00fe, CatMinusOne, 16'd0, 9'd0));
    send(mk_req(nesc_pkg::ActRecord, KindEth, DirRecv, 16'h1234, CatMain, 16'h8000, 9'd0));
    // simple bins, unknown kind
    send(mk_req(nesc_pkg::ActRecord, KindBuffer, 8'h1b, 16'd0, 16'd0, 16'd0, 9'd0));
    send(mk_req(nesc_pkg::ActRecord, KindPort, 8'hff, 16'd0, 16'd0, 16'd0, 9'd0));
    send(mk_req(nesc_pkg::ActRecord, 8'hff, DirSend, 16'd0, CatMain, 16'd0, 9'd0));
    // reads at the last counter of the store and past it, then clear
    send(mk_req(nesc_pkg::ActRead, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 9'd382));
    send(mk_req(nesc_pkg::ActRead, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 9'd511));
    send(mk_req(nesc_pkg::ActClear, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 9'd0));
    wait_idle();

    // extreme type codes, private protocol zero
    write_reg(nesc_pkg::RegTypeRemoteCall, 16'h0000);
    write_reg(nesc_pkg::RegTypeDiskless,   16'hffff);
    write_reg(nesc_pkg::RegTypeUpdateSync, 16'h8000);
    write_reg(nesc_pkg::RegTypeBroadcast,  16'h7fff);
    write_reg(nesc_pkg::RegTypeNameSvc,    16'h0001);
    write_reg(nesc_pkg::RegProtoPrivate,   {8'($urandom), 8'h00});
    send_random(175);
    wait_idle();

    // colliding type codes, then a disabled stretch
    src_idle_pct = 69;
    snk_idle_pct = 9;
    write_reg(nesc_pkg::RegTypeRemoteCall, 16'h0011);
    write_reg(nesc_pkg::RegTypeBroadcast,  16'h0011);
    write_reg(nesc_pkg::RegTypeDiskless,   16'h0022);
    write_reg(nesc_pkg::RegTypeUpdateSync, 16'h0022);
    write_reg(nesc_pkg::RegTypeNameSvc,    16'h0022);
    write_reg(nesc_pkg::RegProtoPrivate,   16'h00ff);
    send_random(150);
    wait_idle();
    write_reg(nesc_pkg::RegEnable, {15'($urandom), 1'b0});
    send_random(25);
    wait_idle();
    write_reg(nesc_pkg::RegEnable, {15'($urandom), 1'b1});

    // broadcast shares the diskless code, private protocol equals icmp
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_reg(nesc_pkg::RegTypeRemoteCall, 16'($urandom));
    write_reg(nesc_pkg::RegTypeDiskless,   16'h4321);
    write_reg(nesc_pkg::RegTypeBroadcast,  16'h4321);
    write_reg(nesc_pkg::RegTypeUpdateSync, 16'($urandom));
    write_reg(nesc_pkg::RegTypeNameSvc,    16'hffff);
    write_reg(nesc_pkg::RegProtoPrivate,   {8'($urandom), IpProtoIcmp});
    send_random(175);
    wait_idle();

    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && reply_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
